FILE: rtl/gid_pkg.sv
// Package for the generational ID allocator: sizes, command and status codes,
// control structs between controller and datapath, and the pointer wrap helper.
// No dependencies.
package gid_pkg;

   localparam int MAX_IDS  = 256;
   localparam int GEN_BITS = 16;
   localparam int ID_W     = $clog2(MAX_IDS);
   localparam int CNT_W    = ID_W + 1;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_CREATE  = CMD_W'(0);
   localparam logic [CMD_W-1:0] CMD_DESTROY = CMD_W'(1);
   localparam logic [CMD_W-1:0] CMD_CHECK   = CMD_W'(2);
   localparam logic [CMD_W-1:0] CMD_QUERY   = CMD_W'(3);
   localparam logic [CMD_W-1:0] CMD_CLEAR   = CMD_W'(4);

   localparam logic [STATUS_W-1:0] ST_OK   = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_NO   = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_FULL = STATUS_W'(2);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic latch;         // capture the request word, read slot and queue head
      logic reuse_rd;      // read the slot of the ID popped from the queue
      logic commit_look;   // finish any command that needs no queue pop
      logic commit_reuse;  // finish a create that reuses a queued ID
   } ctl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic need_reuse;    // latched create finds a non-empty reuse queue
      logic out_free;      // result register can take a new word
   } ctl_status_type;

   typedef struct packed {
      logic                alive;
      logic [GEN_BITS-1:0] gen;
   } slot_type;

   function automatic logic [ID_W-1:0] wrap_inc(input logic [ID_W-1:0] x);
      return (x == ID_W'(MAX_IDS - 1)) ? '0 : x + 1'b1;
   endfunction

endpackage

FILE: rtl/gid_if.sv
// Handshake channel interfaces for the generational ID allocator.
// Depends on gid_pkg for field widths.
interface gid_req_if;
   import gid_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [ID_W-1:0]     entity_id;
   logic [GEN_BITS-1:0] entity_gen;

   modport source (output valid, output cmd, output entity_id, output entity_gen,
                   input ready);
   modport sink   (input valid, input cmd, input entity_id, input entity_gen,
                   output ready);
endinterface

interface gid_rsp_if;
   import gid_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ID_W-1:0]     result_id;
   logic [GEN_BITS-1:0] result_gen;
   logic [ID_W-1:0]     active_count;
   logic [ID_W-1:0]     free_count;
   logic [ID_W-1:0]     total_count;

   modport source (output valid, output status, output result_id, output result_gen,
                   output active_count, output free_count, output total_count,
                   input ready);
   modport sink   (input valid, input status, input result_id, input result_gen,
                   input active_count, input free_count, input total_count,
                   output ready);
endinterface

FILE: rtl/gid_ctrl.sv
// Controller state machine of the generational ID allocator.
// Depends on gid_pkg; drives the datapath through ctl_cmd_type.
module gid_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  gid_pkg::ctl_status_type stat,
   output gid_pkg::ctl_cmd_type    ctl
);
   import gid_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOOK  = 2'd1;
   localparam logic [1:0] S_REUSE = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.latch = 1'b1;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            if (stat.need_reuse) begin
               ctl.reuse_rd = 1'b1;
               state_in     = S_REUSE;
            end else if (stat.out_free) begin
               ctl.commit_look = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_REUSE: begin
            if (stat.out_free) begin
               ctl.commit_reuse = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/gid_datapath.sv
// Datapath of the generational ID allocator: slot and reuse-queue memories,
// counters and the result register. Depends on gid_pkg.
module gid_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  gid_pkg::ctl_cmd_type              ctl,
   output gid_pkg::ctl_status_type           stat,
   input  logic [gid_pkg::CMD_W-1:0]         req_cmd,
   input  logic [gid_pkg::ID_W-1:0]          req_entity_id,
   input  logic [gid_pkg::GEN_BITS-1:0]      req_entity_gen,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gid_pkg::STATUS_W-1:0]      rsp_status,
   output logic [gid_pkg::ID_W-1:0]          rsp_result_id,
   output logic [gid_pkg::GEN_BITS-1:0]      rsp_result_gen,
   output logic [gid_pkg::ID_W-1:0]          rsp_active_count,
   output logic [gid_pkg::ID_W-1:0]          rsp_free_count,
   output logic [gid_pkg::ID_W-1:0]          rsp_total_count
);
   import gid_pkg::*;

   slot_type            slot_mem [MAX_IDS];
   logic [ID_W-1:0]     queue_mem [MAX_IDS];

   logic [CMD_W-1:0]    cmd_ff;
   logic [ID_W-1:0]     id_ff;
   logic [GEN_BITS-1:0] gen_ff;
   slot_type            slot_rd_ff;
   logic [ID_W-1:0]     qrd_ff;

   logic [ID_W-1:0]     head_ff, head_in;
   logic [ID_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]    fresh_ff, fresh_in;
   logic [ID_W-1:0]     live_ff, live_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ID_W-1:0]     rid_ff, rid_in;
   logic [GEN_BITS-1:0] rgen_ff, rgen_in;
   logic [ID_W-1:0]     active_ff, free_ff, total_ff;

   logic                slot_rd_en;
   logic [ID_W-1:0]     slot_raddr;
   logic                slot_we;
   logic [ID_W-1:0]     slot_waddr;
   slot_type            slot_wdata;
   logic                q_we;
   logic                issued, handle_ok, fresh_avail, load;

   assign issued      = (id_ff != '0) && ({1'b0, id_ff} < fresh_ff);
   assign handle_ok   = issued && slot_rd_ff.alive && (slot_rd_ff.gen == gen_ff);
   assign fresh_avail = fresh_ff < CNT_W'(MAX_IDS);
   assign load        = ctl.commit_look | ctl.commit_reuse;

   assign slot_rd_en  = ctl.latch | ctl.reuse_rd;
   assign slot_raddr  = ctl.latch ? req_entity_id : qrd_ff;

   assign stat.need_reuse = (cmd_ff == CMD_CREATE) && (fill_ff != '0);
   assign stat.out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      fill_in    = fill_ff;
      fresh_in   = fresh_ff;
      live_in    = live_ff;
      status_in  = ST_NO;
      rid_in     = '0;
      rgen_in    = '0;
      slot_we    = 1'b0;
      slot_waddr = id_ff;
      slot_wdata = '{alive: 1'b0, gen: slot_rd_ff.gen};
      q_we       = 1'b0;
      if (ctl.commit_reuse) begin
         rid_in     = qrd_ff;
         rgen_in    = slot_rd_ff.gen + 1'b1;
         slot_we    = 1'b1;
         slot_waddr = qrd_ff;
         slot_wdata = '{alive: 1'b1, gen: rgen_in};
         head_in    = wrap_inc(head_ff);
         fill_in    = fill_ff - 1'b1;
         live_in    = live_ff + 1'b1;
         status_in  = ST_OK;
      end else if (ctl.commit_look) begin
         case (cmd_ff)
            CMD_CREATE: begin
               if (fresh_avail) begin
                  rid_in     = fresh_ff[ID_W-1:0];
                  slot_we    = 1'b1;
                  slot_waddr = fresh_ff[ID_W-1:0];
                  slot_wdata = '{alive: 1'b1, gen: '0};
                  fresh_in   = fresh_ff + 1'b1;
                  live_in    = live_ff + 1'b1;
                  status_in  = ST_OK;
               end else begin
                  status_in = ST_FULL;
               end
            end
            CMD_DESTROY: begin
               if (handle_ok) begin
                  slot_we   = 1'b1;
                  q_we      = 1'b1;
                  tail_in   = wrap_inc(tail_ff);
                  fill_in   = fill_ff + 1'b1;
                  live_in   = live_ff - 1'b1;
                  status_in = ST_OK;
               end
            end
            CMD_CHECK: status_in = handle_ok ? ST_OK : ST_NO;
            CMD_QUERY: status_in = (issued && slot_rd_ff.alive) ? ST_OK : ST_NO;
            CMD_CLEAR: begin
               head_in   = '0;
               tail_in   = '0;
               fill_in   = '0;
               fresh_in  = CNT_W'(1);
               live_in   = '0;
               status_in = ST_OK;
            end
            default: status_in = ST_NO;
         endcase
      end
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // memories
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      if (slot_rd_en) begin
         slot_rd_ff <= slot_mem[slot_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         queue_mem[tail_ff] <= id_ff;
      end
      if (ctl.latch) begin
         qrd_ff <= queue_mem[head_ff];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff <= req_cmd;
         id_ff  <= req_entity_id;
         gen_ff <= req_entity_gen;
      end
      if (load) begin
         status_ff <= status_in;
         rid_ff    <= rid_in;
         rgen_ff   <= rgen_in;
         active_ff <= live_in;
         free_ff   <= fill_in[ID_W-1:0];
         total_ff  <= ID_W'(fresh_in - 1'b1);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         fresh_ff     <= CNT_W'(1);
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         fresh_ff     <= fresh_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_id    = rid_ff;
   assign rsp_result_gen   = rgen_ff;
   assign rsp_active_count = active_ff;
   assign rsp_free_count   = free_ff;
   assign rsp_total_count  = total_ff;

endmodule

FILE: rtl/generational_id_allocator.sv
// Generational ID allocator, top level.
// Request channel req_chan carries one command word (cmd, entity_id,
// entity_gen); response channel rsp_chan returns one result word per command
// with status, the created ID and generation, and the active, free and total
// counts after the command. Both use valid/ready; a word moves when both are
// high at a rising edge.
// Sequencing: a word is taken in the idle state; create, destroy, check,
// query and clear finish in the look-up state once the result register is
// free. A create that reuses a queued ID passes through the reuse-read state
// too: the popped ID is read from the reuse queue before its slot is read,
// as the single slot memory port gives one registered read per step.
// Reset (synchronous, active high) empties the reuse queue, sets the next
// fresh ID to 1 and clears the live count; the memories are not swept, as no
// slot at or above the fresh pointer and no empty queue entry is ever used.
// When the receiver stalls, the result word waits in the output register;
// a new command is still taken, and held before its commit until the
// register is free.
module generational_id_allocator (
   input logic clock,
   input logic reset,
   gid_req_if.sink   req_chan,
   gid_rsp_if.source rsp_chan
);
   import gid_pkg::*;

   ctl_cmd_type    ctl;
   ctl_status_type stat;

   // sequencer: idle, look-up, reuse read
   gid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // memories, counters and result register
   gid_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_cmd          (req_chan.cmd),
      .req_entity_id    (req_chan.entity_id),
      .req_entity_gen   (req_chan.entity_gen),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_status       (rsp_chan.status),
      .rsp_result_id    (rsp_chan.result_id),
      .rsp_result_gen   (rsp_chan.result_gen),
      .rsp_active_count (rsp_chan.active_count),
      .rsp_free_count   (rsp_chan.free_count),
      .rsp_total_count  (rsp_chan.total_count)
   );

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for generational_id_allocator: drives command words, predicts
// every result word from a private copy of the slot tables and compares field by field.
// Depends on gid_pkg and the gid_req_if / gid_rsp_if channel interfaces.
module testbench;
   import gid_pkg::*;

   // Spare command codes: the block must reject these and change nothing
   localparam logic [CMD_W-1:0] CMD_SPARE_5 = CMD_W'(5);
   localparam logic [CMD_W-1:0] CMD_SPARE_6 = CMD_W'(6);
   localparam logic [CMD_W-1:0] CMD_SPARE_7 = CMD_W'(7);

   localparam int RANDOM_WORDS = 600;
   localparam int FILL_CREATES = 262;     // enough to run the fresh counter dry
   localparam int HOLD_AT      = 60;      // request words taken before the long hold
   localparam int HOLD_LEN     = 300;
   localparam int STALL_LIMIT  = 4000;    // cycles with no word moving on either side
   localparam int DRAIN_CYCLES = 16;

   typedef enum int {MIX_BUILD, MIX_DRAIN, MIX_EVEN} mix_type;
   typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE, READY_BURSTY} ready_type;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [ID_W-1:0]     id;
      logic [GEN_BITS-1:0] gen;
   } cmd_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     rid;
      logic [GEN_BITS-1:0] rgen;
      logic [ID_W-1:0]     active;
      logic [ID_W-1:0]     free;
      logic [ID_W-1:0]     total;
   } alloc_result_type;

   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [GEN_BITS-1:0] gen;
   } handle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gid_req_if req_chan();
   gid_rsp_if rsp_chan();

   generational_id_allocator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Private copy of the allocator: slot tables, reuse FIFO, counters
   logic [GEN_BITS-1:0] slot_gen   [MAX_IDS];
   bit                  slot_alive [MAX_IDS];
   logic [ID_W-1:0]     freed_ids  [$];
   int                  fresh_id = 1;
   int                  live_cnt = 0;

   handle_type       live_handles [$];   // handles alive after the words taken so far
   cmd_word_type     cmd_backlog  [$];   // words waiting for the driver
   alloc_result_type result_due   [$];   // results owed by the block, oldest first

   int  errors       = 0;
   int  words_in     = 0;
   int  quiet_cycles = 0;
   int  burst_left   = 0;
   int  gap_left     = 0;
   int  hold_left    = 0;
   bit  hold_done    = 1'b0;
   int  seg_left     = 0;
   ready_type ready_mode = READY_ALWAYS;

   always #10 clock = ~clock;

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic bit handle_ok(input logic [ID_W-1:0] id, input logic [GEN_BITS-1:0] g);
      return id != 0 && int'(id) < fresh_id && slot_alive[id] && slot_gen[id] == g;
   endfunction

   // Apply one accepted command word to the private tables and queue the result it owes
   function automatic void run_command(input cmd_word_type w);
      alloc_result_type r;
      handle_type       h;
      int               i;
      r        = '0;
      r.status = ST_NO;
      case (w.cmd)
         CMD_CREATE: begin
            if (freed_ids.size() != 0) begin
               // reuse the oldest freed slot, bump its generation (wraps at the width)
               r.rid           = freed_ids.pop_front();
               slot_gen[r.rid] = slot_gen[r.rid] + 1'b1;
               r.rgen          = slot_gen[r.rid];
               r.status        = ST_OK;
            end else if (fresh_id < MAX_IDS) begin
               r.rid           = ID_W'(fresh_id);
               fresh_id        = fresh_id + 1;
               slot_gen[r.rid] = '0;
               r.rgen          = '0;
               r.status        = ST_OK;
            end else begin
               r.status = ST_FULL;
            end
            if (r.status == ST_OK) begin
               slot_alive[r.rid] = 1'b1;
               live_cnt          = live_cnt + 1;
               h.id              = r.rid;
               h.gen             = r.rgen;
               live_handles      = {live_handles, h};
            end
         end
         CMD_DESTROY: begin
            if (handle_ok(w.id, w.gen)) begin
               slot_alive[w.id] = 1'b0;
               live_cnt         = live_cnt - 1;
               freed_ids        = {freed_ids, w.id};
               r.status = ST_OK;
               for (i = 0; i < live_handles.size(); i++) begin
                  if (live_handles[i].id == w.id) begin
                     live_handles.delete(i);
                     break;
                  end
               end
            end
         end
         CMD_CHECK: begin
            if (handle_ok(w.id, w.gen)) r.status = ST_OK;
         end
         CMD_QUERY: begin
            if (w.id != 0 && int'(w.id) < fresh_id && slot_alive[w.id]) r.status = ST_OK;
         end
         CMD_CLEAR: begin
            foreach (slot_alive[j]) slot_alive[j] = 1'b0;
            freed_ids.delete();
            live_handles.delete();
            fresh_id = 1;
            live_cnt = 0;
            r.status = ST_OK;
         end
         default: r.status = ST_NO;
      endcase
      r.active   = ID_W'(live_cnt);
      r.free     = ID_W'(freed_ids.size());
      r.total    = ID_W'(fresh_id - 1);
      result_due = {result_due, r};
   endfunction

   // ------------------------------------------------------------------
   // Request driver: bursts of words with random gaps in between
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      cmd_word_type nxt;
      if (reset) begin
         req_chan.valid      <= 1'b0;
         req_chan.cmd        <= CMD_QUERY;
         req_chan.entity_id  <= '0;
         req_chan.entity_gen <= '0;
      end else begin
         // predict on acceptance, in the order the block sees the words
         if (req_chan.valid && req_chan.ready) begin
            run_command('{cmd: req_chan.cmd, id: req_chan.entity_id, gen: req_chan.entity_gen});
            words_in <= words_in + 1;
         end
         // the current word is gone or was never offered: choose what to present next
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left != 0) begin
               req_chan.valid <= 1'b0;
               gap_left       <= gap_left - 1;
            end else if (cmd_backlog.size() != 0) begin
               nxt                  = cmd_backlog.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.cmd        <= nxt.cmd;
               req_chan.entity_id  <= nxt.id;
               req_chan.entity_gen <= nxt.gen;
               if (burst_left <= 1) begin
                  // one burst in ten runs long with no idling at all
                  burst_left <= ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 24);
                  gap_left   <= $urandom_range(0, 8);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Result receiver: one long hold-off, then stall patterns picked per stretch
   // ------------------------------------------------------------------
   always @(posedge clock) begin : drive_rsp_ready
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (!hold_done && words_in >= HOLD_AT) begin
         // hold off while the sender keeps offering, so the block fills and stalls its input
         rsp_chan.ready <= 1'b0;
         hold_left      <= HOLD_LEN;
         hold_done      <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            ready_mode <= ready_type'($urandom_range(0, 3));
            seg_left   <= $urandom_range(20, 200);
         end else begin
            seg_left <= seg_left - 1;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_chan.ready <= 1'b1;
            READY_HALF:   rsp_chan.ready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default:      rsp_chan.ready <= ((seg_left % 16) < 8);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Result monitor
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      errors = errors + 1;
      if (errors <= 40)
         $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin : check_rsp
      alloc_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (result_due.size() == 0) begin
            report_mismatch("unexpected result word, status", rsp_chan.status, 0);
         end else begin
            want = result_due.pop_front();
            if (rsp_chan.status !== want.status)
               report_mismatch("status", rsp_chan.status, want.status);
            if (rsp_chan.result_id !== want.rid)
               report_mismatch("result_id", rsp_chan.result_id, want.rid);
            if (rsp_chan.result_gen !== want.rgen)
               report_mismatch("result_gen", rsp_chan.result_gen, want.rgen);
            if (rsp_chan.active_count !== want.active)
               report_mismatch("active_count", rsp_chan.active_count, want.active);
            if (rsp_chan.free_count !== want.free)
               report_mismatch("free_count", rsp_chan.free_count, want.free);
            if (rsp_chan.total_count !== want.total)
               report_mismatch("total_count", rsp_chan.total_count, want.total);
         end
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: count cycles in which no word moves on either channel
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      wait (quiet_cycles >= STALL_LIMIT);
      $display("testbench: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   // Keep the backlog short so that handles picked from the live list are
   // at most three words behind the block.
   task automatic offer(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] id,
                        input logic [GEN_BITS-1:0] g);
      cmd_word_type w;
      w.cmd = c;
      w.id  = id;
      w.gen = g;
      while (cmd_backlog.size() >= 2) @(negedge clock);
      cmd_backlog = {cmd_backlog, w};
   endtask

   // Mostly live handles, some with one generation bit flipped, the rest anything
   function automatic handle_type pick_handle();
      handle_type h;
      int         k;
      k = $urandom_range(0, 9);
      if (live_handles.size() != 0 && k < 9) begin
         h = live_handles[$urandom_range(0, live_handles.size() - 1)];
         if (k >= 7) h.gen = h.gen ^ (GEN_BITS'(1) << $urandom_range(0, GEN_BITS - 1));
      end else begin
         h = '{id: ID_W'($urandom), gen: GEN_BITS'($urandom)};
      end
      return h;
   endfunction

   task automatic random_word(input mix_type mode);
      int               roll;
      int               cre;
      int               des;
      handle_type       h;
      logic [CMD_W-1:0] spare;
      case (mode)
         MIX_BUILD: begin cre = 550; des = 200; end
         MIX_DRAIN: begin cre = 150; des = 550; end
         default:   begin cre = 350; des = 350; end
      endcase
      roll = $urandom_range(0, 999);
      h    = pick_handle();
      if (roll < cre)
         offer(CMD_CREATE, ID_W'($urandom), GEN_BITS'($urandom));
      else if (roll < cre + des)
         offer(CMD_DESTROY, h.id, h.gen);
      else if (roll >= 997)
         offer(CMD_CLEAR, ID_W'($urandom), GEN_BITS'($urandom));
      else if (roll >= 982) begin
         case ($urandom_range(0, 2))
            0:       spare = CMD_SPARE_5;
            1:       spare = CMD_SPARE_6;
            default: spare = CMD_SPARE_7;
         endcase
         offer(spare, h.id, h.gen);
      end
      else if (roll[0])
         offer(CMD_CHECK, h.id, h.gen);
      else
         offer(CMD_QUERY, ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : h.id,
               GEN_BITS'($urandom));
   endtask

   initial begin : stimulus
      int      n;
      int      creates;
      mix_type mode;

      wait (!reset);
      @(negedge clock);

      // Directed: invalid and unissued ids, stale handles, reuse, spare codes, clear
      offer(CMD_QUERY,   '0,              '0);
      offer(CMD_CHECK,   '0,              '0);
      offer(CMD_DESTROY, ID_W'(1),        '0);
      offer(CMD_CREATE,  '1,              '1);
      offer(CMD_CREATE,  '0,              '0);
      offer(CMD_CHECK,   ID_W'(1),        '0);
      offer(CMD_CHECK,   ID_W'(1),        '1);
      offer(CMD_QUERY,   '1,              '0);
      offer(CMD_DESTROY, ID_W'(2),        GEN_BITS'(1));
      offer(CMD_DESTROY, ID_W'(1),        '0);
      offer(CMD_DESTROY, ID_W'(1),        '0);
      offer(CMD_QUERY,   ID_W'(1),        '0);
      offer(CMD_CHECK,   ID_W'(1),        '0);
      offer(CMD_CREATE,  '0,              '0);
      offer(CMD_CHECK,   ID_W'(1),        GEN_BITS'(1));
      offer(CMD_SPARE_5, '1,              '1);
      offer(CMD_SPARE_6, ID_W'(2),        '0);
      offer(CMD_SPARE_7, '1,              '1);
      offer(CMD_DESTROY, '0,              '0);
      offer(CMD_QUERY,   ID_W'(2),        '1);
      offer(CMD_CLEAR,   '1,              '1);
      offer(CMD_QUERY,   ID_W'(1),        '0);
      offer(CMD_CHECK,   ID_W'(2),        '0);
      offer(CMD_CREATE,  '1,              '0);
      offer(CMD_CHECK,   '1,              '1);

      // Fill from empty until the fresh counter runs out and create reports full,
      // with queries and checks mixed in
      offer(CMD_CLEAR, ID_W'($urandom), GEN_BITS'($urandom));
      creates = 0;
      while (creates < FILL_CREATES) begin
         if ($urandom_range(0, 4) != 0) begin
            offer(CMD_CREATE, ID_W'($urandom), GEN_BITS'($urandom));
            creates = creates + 1;
         end else begin
            offer(($urandom_range(0, 1) != 0) ? CMD_QUERY : CMD_CHECK,
                  ID_W'($urandom), GEN_BITS'($urandom_range(0, 1)));
         end
      end

      // Random mix in stretches that build up, drain or balance the live set
      mode = MIX_DRAIN;
      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) mode = mix_type'($urandom_range(0, 2));
         random_word(mode);
      end

      // Drain: wait for every owed result, then idle on to catch stray result words
      while (cmd_backlog.size() != 0 || req_chan.valid || result_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (errors == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule

FILE: generational_id_allocator.f
rtl/gid_pkg.sv
rtl/gid_if.sv
rtl/gid_ctrl.sv
rtl/gid_datapath.sv
rtl/generational_id_allocator.sv
dv/testbench.sv
